FILE: design/wahd_pkg.sv
// Shared types and constants for the in-place WAH bitmap decompressor.
// No dependencies; every design file but wahd_checker imports this package.
package wahd_pkg;

    localparam int unsigned SlotBits  = 32;
    localparam int unsigned GroupBits = 31;
    localparam int unsigned LenBits   = 30;
    localparam int unsigned CountBits = 5;

    localparam int unsigned FillFlagBit  = 31;
    localparam int unsigned FillValueBit = 30;

    // One classified slot handed from the front to the packer
    typedef struct packed {
        logic                 has_group;
        logic [GroupBits-1:0] group;
        logic                 last;
        logic                 bad;
    } wahd_op_t;

    // One decompressed result word
    typedef struct packed {
        logic [SlotBits-1:0] word;
        logic                eoo;
        logic                bad;
    } wahd_res_t;

endpackage

FILE: design/wahd_front.sv
// Front end: tracks open fill runs and the malformed flag, classifies each slot.
// Depends on wahd_pkg.
module wahd_front
    import wahd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [SlotBits-1:0] slot_word,
    input  logic                last_slot,
    output logic                op_valid,
    output wahd_op_t            op
);

    logic [LenBits-1:0] run_rem_reg, run_rem_next;
    logic               run_val_reg, run_val_next;
    logic               bad_reg,     bad_next;

    always_comb
    begin
        logic [LenBits-1:0] len;
        logic               has_group;
        logic [GroupBits-1:0] group;
        len          = slot_word[LenBits-1:0];
        has_group    = 1'b1;
        group        = '0;
        run_rem_next = run_rem_reg;
        run_val_next = run_val_reg;
        bad_next     = bad_reg;

        if (run_rem_reg != '0)
        begin
            group        = {GroupBits{run_val_reg}};
            run_rem_next = run_rem_reg - LenBits'(1);
        end
        else if (slot_word[FillFlagBit])
        begin
            if (len == '0)
            begin
                bad_next  = 1'b1;
                has_group = 1'b0;
            end
            else
            begin
                run_val_next = slot_word[FillValueBit];
                group        = {GroupBits{slot_word[FillValueBit]}};
                run_rem_next = len - LenBits'(1);
            end
        end
        else
        begin
            group = slot_word[GroupBits-1:0];
        end

        // truncate a run that reaches past the final slot
        if (last_slot && run_rem_next != '0)
        begin
            bad_next     = 1'b1;
            run_rem_next = '0;
        end

        op.has_group = has_group;
        op.group     = group;
        op.last      = last_slot;
        op.bad       = bad_next;
        op_valid     = accept && (has_group || last_slot);

        if (last_slot)
        begin
            run_rem_next = '0;
            run_val_next = 1'b0;
            bad_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_rem_reg <= '0;
            run_val_reg <= 1'b0;
            bad_reg     <= 1'b0;
        end
        else if (accept)
        begin
            run_rem_reg <= run_rem_next;
            run_val_reg <= run_val_next;
            bad_reg     <= bad_next;
        end
    end

endmodule

FILE: design/wahd_op_fifo.sv
// Short queue of classified slots between the front end and the packer.
// Depends on wahd_pkg.
module wahd_op_fifo
    import wahd_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  wahd_op_t wr_data,
    input  logic     rd_en,
    output wahd_op_t rd_data,
    output logic     full,
    output logic     empty
);

    localparam int unsigned PtrBits = $clog2(DEPTH);
    localparam int unsigned CntBits = $clog2(DEPTH + 1);

    wahd_op_t            mem [DEPTH];
    logic [PtrBits-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CntBits-1:0]  count_reg, count_next;
    logic                do_wr, do_rd;

    assign full    = (count_reg == CntBits'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CntBits'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CntBits'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrBits'(DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PtrBits'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrBits'(DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PtrBits'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: design/wahd_pack.sv
// Back end: repacks 31-bit groups into 32-bit words and flushes on the last slot.
// Depends on wahd_pkg.
module wahd_pack
    import wahd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    input  wahd_op_t  op,
    input  logic      room,
    output logic      op_pop,
    output logic [1:0] res_cnt,
    output wahd_res_t res0,
    output wahd_res_t res1
);

    logic [GroupBits-1:0] pend_reg, pend_next;
    logic [CountBits-1:0] cnt_reg,  cnt_next;

    assign op_pop = op_valid && room;

    always_comb
    begin
        logic [2*GroupBits-1:0] acc;
        logic [2*GroupBits-1:0] shifted;
        logic [CountBits-1:0]   keep;
        logic [2*SlotBits-2:0]  flush_tmp;
        logic                   have_word;
        logic [SlotBits-1:0]    word;
        acc       = {pend_reg, op.group};
        keep      = cnt_reg - CountBits'(1);
        shifted   = acc >> keep;
        word      = shifted[SlotBits-1:0];
        have_word = 1'b0;
        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        res0      = '{word: word, eoo: 1'b0, bad: op.bad};
        res1      = '{word: '0, eoo: 1'b1, bad: op.bad};
        res_cnt   = 2'd0;
        flush_tmp = '0;

        if (op.has_group)
        begin
            if (cnt_reg == '0)
            begin
                pend_next = op.group;
                cnt_next  = CountBits'(GroupBits);
            end
            else
            begin
                have_word = 1'b1;
                pend_next = op.group & ((GroupBits'(1) << keep) - GroupBits'(1));
                cnt_next  = keep;
                res_cnt   = 2'd1;
            end
        end

        if (op.last)
        begin
            flush_tmp = {{(SlotBits-1){1'b0}}, 1'b0, pend_next}
                        << (6'(SlotBits) - {1'b0, cnt_next});
            if (cnt_next != '0)
            begin
                if (have_word)
                begin
                    res1.word = flush_tmp[SlotBits-1:0];
                    res_cnt   = 2'd2;
                end
                else
                begin
                    res0.word = flush_tmp[SlotBits-1:0];
                    res0.eoo  = 1'b1;
                    res_cnt   = 2'd1;
                end
            end
            else if (!have_word)
            begin
                res0.word = '0;
                res0.eoo  = 1'b1;
                res_cnt   = 2'd1;
            end
            else
            begin
                res0.eoo = 1'b1;
            end
            pend_next = '0;
            cnt_next  = '0;
        end

        if (!op_pop)
        begin
            res_cnt = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (op_pop)
        begin
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

FILE: design/wahd_res_fifo.sv
// Result queue: takes up to two words a cycle from the packer, gives up to one a cycle.
// Depends on wahd_pkg.
module wahd_res_fifo
    import wahd_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] wr_cnt,
    input  wahd_res_t  wr0,
    input  wahd_res_t  wr1,
    input  logic       rd_en,
    output wahd_res_t  rd_data,
    output logic       room,
    output logic       empty
);

    localparam int unsigned PtrBits = $clog2(DEPTH);
    localparam int unsigned CntBits = $clog2(DEPTH + 1);

    wahd_res_t           mem [DEPTH];
    logic [PtrBits-1:0]  wr_ptr_reg, rd_ptr_reg, wr_ptr1, wr_ptr2;
    logic [CntBits-1:0]  count_reg;
    logic                do_rd;

    assign empty   = (count_reg == '0);
    assign room    = (count_reg <= CntBits'(DEPTH - 2));
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];
    assign wr_ptr1 = (wr_ptr_reg == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrBits'(1);
    assign wr_ptr2 = (wr_ptr1 == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr1 + PtrBits'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_reg + CntBits'(wr_cnt) - CntBits'(do_rd);
            case (wr_cnt)
                2'd1:    wr_ptr_reg <= wr_ptr1;
                2'd2:    wr_ptr_reg <= wr_ptr2;
                default: wr_ptr_reg <= wr_ptr_reg;
            endcase
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrBits'(DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PtrBits'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= wr0;
        end
        if (wr_cnt == 2'd2)
        begin
            mem[wr_ptr1] <= wr1;
        end
    end

endmodule

FILE: design/wah_in_place_bitmap_decompress.sv
// Top level of the in-place WAH bitmap decompressor.
// Depends on wahd_pkg, wahd_front, wahd_op_fifo, wahd_pack, wahd_res_fifo.
//
// Usage:
//   Input queue: drive slot_word and last_slot, raise push; a slot transfers
//   on a clock edge with push high and full low. One slot per cycle is
//   taken sustained while full stays low.
//   Result queue: while empty is low, out_word, end_of_output and malformed
//   show the oldest result; it transfers on an edge with pop high.
//   Each slot gives zero or one word; the last slot of a bitmap gives one
//   or two (a completed word and the zero-padded flush), the final one
//   marked by end_of_output.
// Pipeline: the front end classifies a slot in its transfer cycle and
//   writes it into the slot queue; the packer moves it on into the result
//   queue, handling one slot a cycle when the result queue has room for
//   two words.
// Reset: rst_n clears runs, buffered bits, the malformed flag and both queues.
// Stall: when pop stays low the result queue fills, the packer holds, the
//   slot queue fills and full rises; nothing is dropped.
module wah_in_place_bitmap_decompress
    import wahd_pkg::*;
#(
    parameter int unsigned OP_DEPTH  = 2,
    parameter int unsigned RES_DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [SlotBits-1:0] slot_word,
    input  logic                last_slot,
    output logic                empty,
    input  logic                pop,
    output logic [SlotBits-1:0] out_word,
    output logic                end_of_output,
    output logic                malformed
);

    logic      accept;
    logic      op_wr;
    wahd_op_t  op_in, op_out;
    logic      op_empty, op_pop;
    logic      room;
    logic [1:0] res_cnt;
    wahd_res_t res0, res1, res_out;

    assign accept = push && !full;

    wahd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .slot_word (slot_word),
        .last_slot (last_slot),
        .op_valid  (op_wr),
        .op        (op_in)
    );

    wahd_op_fifo #(.DEPTH(OP_DEPTH)) u_op_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (op_wr),
        .wr_data (op_in),
        .rd_en   (op_pop),
        .rd_data (op_out),
        .full    (full),
        .empty   (op_empty)
    );

    wahd_pack u_pack (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (!op_empty),
        .op       (op_out),
        .room     (room),
        .op_pop   (op_pop),
        .res_cnt  (res_cnt),
        .res0     (res0),
        .res1     (res1)
    );

    wahd_res_fifo #(.DEPTH(RES_DEPTH)) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_cnt  (res_cnt),
        .wr0     (res0),
        .wr1     (res1),
        .rd_en   (pop),
        .rd_data (res_out),
        .room    (room),
        .empty   (empty)
    );

    assign out_word      = res_out.word;
    assign end_of_output = res_out.eoo;
    assign malformed     = res_out.bad;

endmodule

FILE: design/wahd_checker.sv
// Port-level checks for the WAH bitmap decompressor, bound to the top level.
// Depends only on the top level's ports.
module wahd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] out_word,
    input logic        end_of_output,
    input logic        malformed
);

    // queues come out of reset empty and able to take a slot
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !full)
        else $error("slot queue full after reset");

    // hold a shown result until it transfers
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_word)
                              && $stable(end_of_output) && $stable(malformed)))
        else $error("waiting result changed before transfer");

endmodule

bind wah_in_place_bitmap_decompress wahd_checker u_wahd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .out_word      (out_word),
    .end_of_output (end_of_output),
    .malformed     (malformed)
);

FILE: dv/wah_in_place_bitmap_decompress_test.sv
// Self-checking bench for wah_in_place_bitmap_decompress: streams WAH bitmaps
// through the slot queue and checks every decompressed word against a local decoder.
// Depends on wahd_pkg and the design top level.
`timescale 1ns / 1ps

module wah_in_place_bitmap_decompress_test;
    import wahd_pkg::*;

    typedef struct packed {
        logic [SlotBits-1:0] word;
        logic                last;
    } slot_item_t;

    typedef enum int {DRAIN, COIN, HOLD, ALTERNATE} pop_mode_t;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [SlotBits-1:0] slot_word;
    logic                last_slot;
    logic                empty;
    logic                pop;
    logic [SlotBits-1:0] out_word;
    logic                end_of_output;
    logic                malformed;

    wah_in_place_bitmap_decompress u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .slot_word     (slot_word),
        .last_slot     (last_slot),
        .empty         (empty),
        .pop           (pop),
        .out_word      (out_word),
        .end_of_output (end_of_output),
        .malformed     (malformed)
    );

    // Decoder state
    logic [GroupBits-1:0] pend_bits;
    logic [CountBits-1:0] pend_cnt;
    logic [LenBits-1:0]   run_left;
    logic                 run_val;
    logic                 bad_flag;

    slot_item_t slot_queue[$];
    wahd_res_t  expected_words[$];

    int        fail_cnt;
    int        slots_queued;
    int        bitmaps_queued;
    int        words_checked;
    int        ends_checked;
    int        bad_words;
    logic      took;
    int        gap_left;
    int        burst_left;
    int        pop_left;
    pop_mode_t pop_mode;

    task automatic decode_slot(input logic [SlotBits-1:0] slot, input logic last);
        logic                   has_grp;
        logic [GroupBits-1:0]   grp;
        logic [2*GroupBits-1:0] acc;
        logic [63:0]            flush;
        int                     keep;
        int                     made;
        wahd_res_t              res;
        has_grp = 1'b1;
        grp = '0;
        made = 0;
        if (run_left != 0)
        begin
            // covered slot: contents ignored
            grp = {GroupBits{run_val}};
            run_left = run_left - 1'b1;
        end
        else if (slot[FillFlagBit])
        begin
            if (slot[LenBits-1:0] == '0)
            begin
                bad_flag = 1'b1;
                has_grp = 1'b0;
            end
            else
            begin
                run_val = slot[FillValueBit];
                grp = {GroupBits{run_val}};
                run_left = slot[LenBits-1:0] - 1'b1;
            end
        end
        else
            grp = slot[GroupBits-1:0];

        // truncate a run that reaches past the bitmap end
        if (last && run_left != 0)
        begin
            bad_flag = 1'b1;
            run_left = '0;
        end

        if (has_grp)
        begin
            acc = {pend_bits, grp};
            if (pend_cnt != 0)
            begin
                keep = pend_cnt - 1;
                res.word = SlotBits'(acc >> keep);
                res.eoo = 1'b0;
                res.bad = bad_flag;
                expected_words.push_back(res);
                made = 1;
                pend_bits = GroupBits'(acc & ((62'd1 << keep) - 62'd1));
                pend_cnt = CountBits'(keep);
            end
            else
            begin
                pend_bits = grp;
                pend_cnt = CountBits'(GroupBits);
            end
        end

        if (last)
        begin
            if (pend_cnt != 0)
            begin
                flush = {33'd0, pend_bits} << (SlotBits - pend_cnt);
                res.word = flush[SlotBits-1:0];
                res.eoo = 1'b1;
                res.bad = bad_flag;
                expected_words.push_back(res);
            end
            else if (made == 0)
            begin
                res.word = '0;
                res.eoo = 1'b1;
                res.bad = bad_flag;
                expected_words.push_back(res);
            end
            else
            begin
                expected_words[$].eoo = 1'b1;
                expected_words[$].bad = bad_flag;
            end
            pend_bits = '0;
            pend_cnt = '0;
            run_left = '0;
            run_val = 1'b0;
            bad_flag = 1'b0;
        end
    endtask

    task automatic queue_slot(input logic [SlotBits-1:0] word, input logic last);
        slot_item_t it;
        it.word = word;
        it.last = last;
        slot_queue.push_back(it);
        slots_queued++;
        if (last)
            bitmaps_queued++;
    endtask

    function automatic logic [SlotBits-1:0] random_literal();
        logic [SlotBits-1:0] w;
        case ($urandom_range(0, 5))
            0: w = 32'h7FFF_FFFF;
            1: w = '0;
            2: w = $urandom & $urandom & 32'h7FFF_FFFF;
            default: w = $urandom & 32'h7FFF_FFFF;
        endcase
        return w;
    endfunction

    // Clean bitmaps only use fills that fit; dirty ones mix in raw words,
    // zero-length fills and runs that overshoot the end.
    task automatic add_bitmap(input int n_slots, input bit clean);
        int                  left;
        int                  len;
        logic [SlotBits-1:0] w;
        left = n_slots;
        while (left > 0)
        begin
            if (!clean && $urandom_range(0, 2) == 0)
            begin
                w = $urandom;
                if (w[FillFlagBit] && $urandom_range(0, 1))
                    w[LenBits-1:0] = LenBits'($urandom_range(0, left + 3));
                queue_slot(w, left == 1);
                left--;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                len = $urandom_range(1, left);
                w = {1'b1, 1'($urandom), LenBits'(len)};
                queue_slot(w, left == 1);
                left--;
                repeat (len - 1)
                begin
                    queue_slot($urandom, left == 1);
                    left--;
                end
            end
            else
            begin
                queue_slot(random_literal(), left == 1);
                left--;
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Slot driver
    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (push && !took)
            ; // hold until the transfer
        else if (gap_left > 0)
        begin
            push <= 1'b0;
            gap_left--;
        end
        else if (slot_queue.size() > 0)
        begin
            slot_word <= slot_queue[0].word;
            last_slot <= slot_queue[0].last;
            void'(slot_queue.pop_front());
            push <= 1'b1;
            if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                         : $urandom_range(1, 8);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            else
                burst_left--;
        end
        else
            push <= 1'b0;
    end

    // Result receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop_left == 0)
            begin
                pop_mode = pop_mode_t'($urandom_range(0, 3));
                pop_left = $urandom_range(5, 60);
            end
            pop_left--;
            case (pop_mode)
                DRAIN:     pop <= 1'b1;
                COIN:      pop <= 1'($urandom);
                HOLD:      pop <= 1'b0;
                ALTERNATE: pop <= ~pop;
            endcase
        end
    end

    always @(posedge clk)
        took <= rst_n && push && !full;

    // Monitor: predict on slot transfer, check on word transfer
    always @(posedge clk)
    begin
        wahd_res_t exp_res;
        if (rst_n)
        begin
            if (push && !full)
                decode_slot(slot_word, last_slot);
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word: out_word %h end_of_output %b malformed %b",
                           out_word, end_of_output, malformed);
                    fail_cnt++;
                end
                else
                begin
                    exp_res = expected_words.pop_front();
                    words_checked++;
                    if (exp_res.eoo)
                        ends_checked++;
                    if (exp_res.bad)
                        bad_words++;
                    if (out_word !== exp_res.word)
                    begin
                        $error("out_word: expected %h, actual %h", exp_res.word, out_word);
                        fail_cnt++;
                    end
                    if (end_of_output !== exp_res.eoo)
                    begin
                        $error("end_of_output: expected %b, actual %b",
                               exp_res.eoo, end_of_output);
                        fail_cnt++;
                    end
                    if (malformed !== exp_res.bad)
                    begin
                        $error("malformed: expected %b, actual %b", exp_res.bad, malformed);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    initial
    begin
        int n;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        slot_word = '0;
        last_slot = 1'b0;
        took = 1'b0;
        pend_bits = '0;
        pend_cnt = '0;
        run_left = '0;
        run_val = 1'b0;
        bad_flag = 1'b0;
        fail_cnt = 0;
        slots_queued = 0;
        bitmaps_queued = 0;
        words_checked = 0;
        ends_checked = 0;
        bad_words = 0;
        gap_left = 0;
        burst_left = 0;
        pop_left = 0;
        pop_mode = DRAIN;

        // Directed: single literals at the extremes, then a two-literal bitmap
        queue_slot(32'h7FFF_FFFF, 1'b1);
        queue_slot(32'h0000_0000, 1'b1);
        queue_slot(32'h4000_0001, 1'b0);
        queue_slot(32'h2AAA_AAAA, 1'b1);
        // one-slot fill of ones on the last slot
        queue_slot(32'hC000_0001, 1'b1);
        // fill of zeros over three slots, covered slots look like fills
        queue_slot(32'h8000_0003, 1'b0);
        queue_slot(32'hFFFF_FFFF, 1'b0);
        queue_slot(32'h8000_0000, 1'b0);
        queue_slot(32'h5555_5555, 1'b1);
        // zero-length fill in the middle, then alone on the last slot
        queue_slot(32'h8000_0000, 1'b0);
        queue_slot(32'h1234_5678, 1'b1);
        queue_slot(32'hC000_0000, 1'b1);
        // run overshooting the end, then a long run ending on its own head
        queue_slot(32'hC000_0005, 1'b0);
        queue_slot(32'h0F0F_0F0F, 1'b1);
        queue_slot(32'hC000_0007, 1'b1);
        // maximum run lengths, both fill values
        queue_slot(32'hFFFF_FFFF, 1'b0);
        queue_slot(32'h0000_0001, 1'b1);
        queue_slot(32'hBFFF_FFFF, 1'b1);
        // fill ending exactly on the last slot
        queue_slot(32'hC000_0002, 1'b0);
        queue_slot(32'h7FFF_FFFF, 1'b1);

        // Random bitmaps, mostly well formed and short
        while (slots_queued < 2020)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
            add_bitmap(n, $urandom_range(0, 4) != 0);
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (slot_queue.size() != 0 || push)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Sent %0d slots in %0d bitmaps; checked %0d words, %0d end markers, %0d malformed",
                 slots_queued, bitmaps_queued, words_checked, ends_checked, bad_words);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
design/wahd_pkg.sv
design/wahd_front.sv
design/wahd_op_fifo.sv
design/wahd_pack.sv
design/wahd_res_fifo.sv
design/wah_in_place_bitmap_decompress.sv
design/wahd_checker.sv
dv/wah_in_place_bitmap_decompress_test.sv
